[hdl/pscd_pkg.sv]
// shared types, constants and fixed-point helpers for the primitive state block
`default_nettype none

package pscd_pkg;

    localparam logic [17:0] GAMMA_MIN   = 18'd65537;
    localparam logic [17:0] GAMMA_MAX   = 18'd196608;
    localparam logic [17:0] GAMMA_RESET = 18'd91750;
    localparam logic [17:0] GAMMA_ONE   = 18'd65536;

    localparam logic signed [31:0] HALF_Q = 32'sd32768;

    // pipeline depth of the divider and of the square root
    localparam int unsigned DIV_LAT  = 34;
    localparam int unsigned SQRT_LAT = 25;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ERR_OK           = 2'd0,
        ERR_BAD_CELL     = 2'd1,
        ERR_NEG_PRESSURE = 2'd2
    } err_t;

    typedef struct packed {
        logic signed [31:0] jinv;
        logic signed [31:0] mass;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] en;
        logic               jbad;
    } item_t;

    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] x_velocity;
        logic signed [31:0] y_velocity;
        logic signed [31:0] total_energy;
        logic signed [31:0] pressure;
        logic        [30:0] sound_speed;
        logic signed [31:0] enthalpy;
        err_t               error_code;
    } result_t;

    function automatic logic signed [31:0] sat_word(input logic signed [63:0] v,
                                                    input int unsigned bits);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
        begin
            return hi[31:0];
        end
        if (v < lo)
        begin
            return lo[31:0];
        end
        return v[31:0];
    endfunction

    // product shifted right by 16, rounded toward minus infinity, saturated
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input int unsigned bits);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return sat_word(p >>> 16, bits);
    endfunction

endpackage

`default_nettype wire

[hdl/pscd_fifo.sv]
// small register queue
`default_nettype none

module pscd_fifo #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [0:DEPTH-1];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

[hdl/pscd_front.sv]
// front end: saturates the incoming cell and flags a bad inverse jacobian
`default_nettype none

module pscd_front #(
    parameter int unsigned SAT_BITS = 32
) (
    input  logic signed [31:0] jacobian_inverse,
    input  logic signed [31:0] mass_term,
    input  logic signed [31:0] x_momentum_term,
    input  logic signed [31:0] y_momentum_term,
    input  logic signed [31:0] energy_term,
    output pscd_pkg::item_t    item
);

    always_comb
    begin
        item.jinv = pscd_pkg::sat_word(64'(jacobian_inverse), SAT_BITS);
        item.mass = pscd_pkg::sat_word(64'(mass_term), SAT_BITS);
        item.mx   = pscd_pkg::sat_word(64'(x_momentum_term), SAT_BITS);
        item.my   = pscd_pkg::sat_word(64'(y_momentum_term), SAT_BITS);
        item.en   = pscd_pkg::sat_word(64'(energy_term), SAT_BITS);
        item.jbad = (item.jinv <= 32'sd0);
    end

endmodule

`default_nettype wire

[hdl/pscd_delay.sv]
// enabled delay line for side data that travels next to the arithmetic units
`default_nettype none

module pscd_delay #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 4
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int k = 1; k < DEPTH; k++)
            begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

`default_nettype wire

[hdl/pscd_div.sv]
// pipelined q16.16 divider, one quotient bit per stage, truncating and saturating
`default_nettype none

module pscd_div #(
    parameter int unsigned SAT_BITS = 32
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [31:0] q
);

    localparam int unsigned STEPS = 32;

    logic [31:0] rem_reg [0:STEPS];
    logic [31:0] low_reg [0:STEPS];
    logic [31:0] quo_reg [0:STEPS];
    logic [31:0] dvs_reg [0:STEPS];
    logic        neg_reg [0:STEPS];
    logic        ovf_reg [0:STEPS];
    logic signed [31:0] q_reg;

    logic [31:0] a_mag, b_mag;
    logic signed [63:0] q_wide;

    assign a_mag = a[31] ? (~a + 32'd1) : a;
    assign b_mag = b[31] ? (~b + 32'd1) : b;

    // quotient of 2^32 or more, or a zero divisor, saturates by sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {16'd0, a_mag[31:16]};
            low_reg[0] <= {a_mag[15:0], 16'd0};
            quo_reg[0] <= '0;
            dvs_reg[0] <= b_mag;
            neg_reg[0] <= a[31] ^ b[31];
            ovf_reg[0] <= ({16'd0, a_mag[31:16]} >= b_mag);
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [32:0] r2;
        logic        ge;
        assign r2 = {rem_reg[k], low_reg[k][31]};
        assign ge = (r2 >= {1'b0, dvs_reg[k]});
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? 32'(r2 - {1'b0, dvs_reg[k]}) : r2[31:0];
                low_reg[k+1] <= {low_reg[k][30:0], 1'b0};
                quo_reg[k+1] <= {quo_reg[k][30:0], ge};
                dvs_reg[k+1] <= dvs_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[STEPS])
        begin
            q_wide = neg_reg[STEPS] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else if (neg_reg[STEPS])
        begin
            q_wide = -$signed({32'd0, quo_reg[STEPS]});
        end
        else
        begin
            q_wide = $signed({32'd0, quo_reg[STEPS]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= pscd_pkg::sat_word(q_wide, SAT_BITS);
        end
    end

    assign q = q_reg;

endmodule

`default_nettype wire

[hdl/pscd_sqrt.sv]
// pipelined floor square root of x * 2^16, one result bit per stage
`default_nettype none

module pscd_sqrt (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] x,
    output logic        [23:0] root
);

    localparam int unsigned STEPS = 24;

    logic [47:0] n_reg [0:STEPS];
    logic [47:0] r_reg [0:STEPS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0] <= (x > 32'sd0) ? {1'b0, x[30:0], 16'd0} : '0;
            r_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        localparam logic [47:0] BIT = 48'd1 << (46 - 2 * k);
        logic [47:0] t;
        logic        ge;
        assign t  = r_reg[k] + BIT;
        assign ge = (n_reg[k] >= t);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k+1] <= ge ? n_reg[k] - t : n_reg[k];
                r_reg[k+1] <= ge ? (r_reg[k] >> 1) + BIT : (r_reg[k] >> 1);
            end
        end
    end

    assign root = r_reg[STEPS][23:0];

endmodule

`default_nettype wire

[hdl/pscd_back.sv]
// back end: division chain, gas law, sound speed and enthalpy in one stalling pipeline
`default_nettype none

module pscd_back #(
    parameter int unsigned SAT_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  pscd_pkg::item_t    in_item,
    output logic               in_take,
    input  logic signed [31:0] g,
    input  logic signed [31:0] gm1,
    output logic               out_push,
    input  logic               out_full,
    output pscd_pkg::result_t  out_res
);

    localparam int unsigned D   = pscd_pkg::DIV_LAT;
    localparam int unsigned LAT = 4 * D + 6 + pscd_pkg::SQRT_LAT;

    typedef struct packed {
        logic signed [31:0] jinv;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic               jbad;
    } c1_t;

    typedef struct packed {
        logic signed [31:0] jinv;
        logic signed [31:0] rho;
        logic signed [31:0] e;
        logic signed [31:0] hr;
        logic signed [31:0] rmg;
        logic               err;
    } c2_t;

    typedef struct packed {
        logic signed [31:0] rho;
        logic signed [31:0] e;
        logic signed [31:0] hr;
        logic signed [31:0] rmg;
        logic               err;
    } c3_t;

    typedef struct packed {
        logic signed [31:0] rho;
        logic signed [31:0] e;
        logic signed [31:0] hr;
        logic signed [31:0] rmg;
        logic signed [31:0] ux;
        logic signed [31:0] vy;
        logic signed [31:0] t0;
        logic signed [31:0] t1;
        logic signed [31:0] hv2;
        logic signed [31:0] p;
        logic               err;
    } stage_t;

    typedef struct packed {
        logic signed [31:0] rho;
        logic signed [31:0] ux;
        logic signed [31:0] vy;
        logic signed [31:0] e;
        logic signed [31:0] p;
        logic signed [31:0] hv2;
        logic               err;
    } c4_t;

    typedef struct packed {
        logic signed [31:0] rho;
        logic signed [31:0] ux;
        logic signed [31:0] vy;
        logic signed [31:0] e;
        logic signed [31:0] p;
        logic signed [31:0] h;
        logic               err;
    } c5_t;

    logic             adv;
    logic [LAT-1:0]   vld_reg;

    logic signed [31:0] rho_a, e_a, tx_b, ty_b, ux_c, vy_c, cq_g, hq_h;
    logic        [23:0] root;
    c1_t    c1_in, c1_out;
    c2_t    c2_in, c2_out;
    c3_t    c3_in, c3_out;
    c4_t    c4_in, c4_out;
    c5_t    c5_in, c5_out;
    stage_t m_reg  [1:6];
    stage_t m_next [1:6];

    // the whole pipeline holds only when a finished item cannot leave
    assign adv      = !vld_reg[LAT-1] || !out_full;
    assign in_take  = adv && in_valid;
    assign out_push = adv && vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], in_take};
        end
    end

    // density and total energy
    pscd_div #(.SAT_BITS(SAT_BITS)) u_div_rho (
        .clk(clk), .en(adv), .a(in_item.mass), .b(in_item.jinv), .q(rho_a)
    );
    pscd_div #(.SAT_BITS(SAT_BITS)) u_div_e (
        .clk(clk), .en(adv), .a(in_item.en), .b(in_item.jinv), .q(e_a)
    );

    always_comb
    begin
        c1_in.jinv = in_item.jinv;
        c1_in.mx   = in_item.mx;
        c1_in.my   = in_item.my;
        c1_in.jbad = in_item.jbad;
    end

    pscd_delay #(.W($bits(c1_t)), .DEPTH(D)) u_dly1 (
        .clk(clk), .en(adv), .din(c1_in), .dout(c1_out)
    );

    // momentum over density
    pscd_div #(.SAT_BITS(SAT_BITS)) u_div_tx (
        .clk(clk), .en(adv), .a(c1_out.mx), .b(rho_a), .q(tx_b)
    );
    pscd_div #(.SAT_BITS(SAT_BITS)) u_div_ty (
        .clk(clk), .en(adv), .a(c1_out.my), .b(rho_a), .q(ty_b)
    );

    always_comb
    begin
        c2_in.jinv = c1_out.jinv;
        c2_in.rho  = rho_a;
        c2_in.e    = e_a;
        c2_in.hr   = pscd_pkg::qmul(pscd_pkg::HALF_Q, rho_a, SAT_BITS);
        c2_in.rmg  = pscd_pkg::qmul(rho_a, gm1, SAT_BITS);
        c2_in.err  = c1_out.jbad || (rho_a <= 32'sd0);
    end

    pscd_delay #(.W($bits(c2_t)), .DEPTH(D)) u_dly2 (
        .clk(clk), .en(adv), .din(c2_in), .dout(c2_out)
    );

    // second division by the inverse jacobian gives the velocities
    pscd_div #(.SAT_BITS(SAT_BITS)) u_div_ux (
        .clk(clk), .en(adv), .a(tx_b), .b(c2_out.jinv), .q(ux_c)
    );
    pscd_div #(.SAT_BITS(SAT_BITS)) u_div_vy (
        .clk(clk), .en(adv), .a(ty_b), .b(c2_out.jinv), .q(vy_c)
    );

    always_comb
    begin
        c3_in.rho = c2_out.rho;
        c3_in.e   = c2_out.e;
        c3_in.hr  = c2_out.hr;
        c3_in.rmg = c2_out.rmg;
        c3_in.err = c2_out.err;
    end

    pscd_delay #(.W($bits(c3_t)), .DEPTH(D)) u_dly3 (
        .clk(clk), .en(adv), .din(c3_in), .dout(c3_out)
    );

    // kinetic energy, pressure and gamma times pressure, in a chain of registered stages
    always_comb
    begin
        m_next[1].rho = c3_out.rho;
        m_next[1].e   = c3_out.e;
        m_next[1].hr  = c3_out.hr;
        m_next[1].rmg = c3_out.rmg;
        m_next[1].err = c3_out.err;
        m_next[1].ux  = ux_c;
        m_next[1].vy  = vy_c;
        m_next[1].t0  = pscd_pkg::qmul(ux_c, ux_c, SAT_BITS);
        m_next[1].t1  = pscd_pkg::qmul(vy_c, vy_c, SAT_BITS);
        m_next[1].hv2 = '0;
        m_next[1].p   = '0;

        // speed squared
        m_next[2]    = m_reg[1];
        m_next[2].t0 = pscd_pkg::sat_word(64'(m_reg[1].t0) + 64'(m_reg[1].t1), SAT_BITS);

        // kinetic energy and half the speed squared
        m_next[3]     = m_reg[2];
        m_next[3].t1  = pscd_pkg::qmul(m_reg[2].hr, m_reg[2].t0, SAT_BITS);
        m_next[3].hv2 = m_reg[2].t0 >>> 1;

        // internal energy
        m_next[4]    = m_reg[3];
        m_next[4].t0 = pscd_pkg::sat_word(64'(m_reg[3].e) - 64'(m_reg[3].t1), SAT_BITS);

        m_next[5]   = m_reg[4];
        m_next[5].p = pscd_pkg::qmul(m_reg[4].t0, gm1, SAT_BITS);

        m_next[6]    = m_reg[5];
        m_next[6].t0 = pscd_pkg::qmul(g, m_reg[5].p, SAT_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 1; k <= 6; k++)
            begin
                m_reg[k] <= m_next[k];
            end
        end
    end

    pscd_div #(.SAT_BITS(SAT_BITS)) u_div_c2 (
        .clk(clk), .en(adv), .a(m_reg[6].t0), .b(m_reg[6].rho), .q(cq_g)
    );
    pscd_div #(.SAT_BITS(SAT_BITS)) u_div_h (
        .clk(clk), .en(adv), .a(m_reg[6].t0), .b(m_reg[6].rmg), .q(hq_h)
    );

    always_comb
    begin
        c4_in.rho = m_reg[6].rho;
        c4_in.ux  = m_reg[6].ux;
        c4_in.vy  = m_reg[6].vy;
        c4_in.e   = m_reg[6].e;
        c4_in.p   = m_reg[6].p;
        c4_in.hv2 = m_reg[6].hv2;
        c4_in.err = m_reg[6].err;
    end

    pscd_delay #(.W($bits(c4_t)), .DEPTH(D)) u_dly4 (
        .clk(clk), .en(adv), .din(c4_in), .dout(c4_out)
    );

    pscd_sqrt u_sqrt (
        .clk(clk), .en(adv), .x(cq_g), .root(root)
    );

    always_comb
    begin
        c5_in.rho = c4_out.rho;
        c5_in.ux  = c4_out.ux;
        c5_in.vy  = c4_out.vy;
        c5_in.e   = c4_out.e;
        c5_in.p   = c4_out.p;
        c5_in.h   = pscd_pkg::sat_word(64'(hq_h) + 64'(c4_out.hv2), SAT_BITS);
        c5_in.err = c4_out.err;
    end

    pscd_delay #(.W($bits(c5_t)), .DEPTH(pscd_pkg::SQRT_LAT)) u_dly5 (
        .clk(clk), .en(adv), .din(c5_in), .dout(c5_out)
    );

    always_comb
    begin
        if (c5_out.err)
        begin
            out_res            = '0;
            out_res.error_code = pscd_pkg::ERR_BAD_CELL;
        end
        else
        begin
            out_res.density      = c5_out.rho;
            out_res.x_velocity   = c5_out.ux;
            out_res.y_velocity   = c5_out.vy;
            out_res.total_energy = c5_out.e;
            out_res.pressure     = c5_out.p;
            out_res.enthalpy     = c5_out.h;
            if (c5_out.p < 32'sd0)
            begin
                out_res.sound_speed = '0;
                out_res.error_code  = pscd_pkg::ERR_NEG_PRESSURE;
            end
            else
            begin
                out_res.sound_speed = {7'd0, root};
                out_res.error_code  = pscd_pkg::ERR_OK;
            end
        end
    end

endmodule

`default_nettype wire

[hdl/primitive_state_from_conserved.sv]
// path: input queue, back-end dividers, product stages and square root, result queue
// throughput: one item per cycle unless held, set by the pipelined dividers and square root
// the back end holds as a whole only while its finished item meets a full result queue
// reset: asynchronous, active low; empties both queues and the pipeline, gamma returns to 1.4
`default_nettype none

module primitive_state_from_conserved #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] jacobian_inverse,
    input  logic signed [31:0] mass_term,
    input  logic signed [31:0] x_momentum_term,
    input  logic signed [31:0] y_momentum_term,
    input  logic signed [31:0] energy_term,
    input  logic               cfg_write,
    input  logic        [17:0] cfg_data,
    output logic               empty,
    input  logic               pop,
    output logic signed [31:0] density,
    output logic signed [31:0] x_velocity,
    output logic signed [31:0] y_velocity,
    output logic signed [31:0] total_energy,
    output logic signed [31:0] pressure,
    output logic        [30:0] sound_speed,
    output logic signed [31:0] enthalpy,
    output logic        [1:0]  error_code
);

    localparam int unsigned SAT_BITS = (WORD_BITS > 32) ? 32 : WORD_BITS;

    logic [17:0] gamma_reg, gamma_next;
    logic [17:0] g_clamp;
    logic [17:0] gm1_narrow;

    pscd_pkg::item_t   front_item, mid_item;
    pscd_pkg::result_t back_res, out_res;
    logic              mid_empty, back_take, back_push, out_full;

    assign gamma_next = cfg_write ? cfg_data : gamma_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= pscd_pkg::GAMMA_RESET;
        end
        else
        begin
            gamma_reg <= gamma_next;
        end
    end

    always_comb
    begin
        if (gamma_reg < pscd_pkg::GAMMA_MIN)
        begin
            g_clamp = pscd_pkg::GAMMA_MIN;
        end
        else if (gamma_reg > pscd_pkg::GAMMA_MAX)
        begin
            g_clamp = pscd_pkg::GAMMA_MAX;
        end
        else
        begin
            g_clamp = gamma_reg;
        end
    end

    assign gm1_narrow = g_clamp - pscd_pkg::GAMMA_ONE;

    pscd_front #(.SAT_BITS(SAT_BITS)) u_front (
        .jacobian_inverse (jacobian_inverse),
        .mass_term        (mass_term),
        .x_momentum_term  (x_momentum_term),
        .y_momentum_term  (y_momentum_term),
        .energy_term      (energy_term),
        .item             (front_item)
    );

    pscd_fifo #(.W($bits(pscd_pkg::item_t)), .DEPTH(pscd_pkg::QUEUE_DEPTH)) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (front_item),
        .full  (full),
        .pop   (back_take),
        .dout  (mid_item),
        .empty (mid_empty)
    );

    pscd_back #(.SAT_BITS(SAT_BITS)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!mid_empty),
        .in_item  (mid_item),
        .in_take  (back_take),
        .g        ({14'd0, g_clamp}),
        .gm1      ({14'd0, gm1_narrow}),
        .out_push (back_push),
        .out_full (out_full),
        .out_res  (back_res)
    );

    pscd_fifo #(.W($bits(pscd_pkg::result_t)), .DEPTH(pscd_pkg::QUEUE_DEPTH)) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_push),
        .din   (back_res),
        .full  (out_full),
        .pop   (pop),
        .dout  (out_res),
        .empty (empty)
    );

    assign density      = out_res.density;
    assign x_velocity   = out_res.x_velocity;
    assign y_velocity   = out_res.y_velocity;
    assign total_energy = out_res.total_energy;
    assign pressure     = out_res.pressure;
    assign sound_speed  = out_res.sound_speed;
    assign enthalpy     = out_res.enthalpy;
    assign error_code   = out_res.error_code;

endmodule

`default_nettype wire

[hdl/pscd_chk.sv]
// port checker for the primitive state block and its bind
`default_nettype none

module pscd_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [31:0] density,
    input logic signed [31:0] pressure,
    input logic        [30:0] sound_speed,
    input logic signed [31:0] enthalpy,
    input logic        [1:0]  error_code
);

    a_code_known: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (error_code == pscd_pkg::ERR_OK || error_code == pscd_pkg::ERR_BAD_CELL
                    || error_code == pscd_pkg::ERR_NEG_PRESSURE))
        else $error("unknown error code on result");

    a_bad_cell_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_code == pscd_pkg::ERR_BAD_CELL) |->
            (density == 32'sd0 && pressure == 32'sd0 && sound_speed == '0
             && enthalpy == 32'sd0))
        else $error("bad cell item carries nonzero fields");

    a_neg_pressure: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_code == pscd_pkg::ERR_NEG_PRESSURE) |->
            (sound_speed == '0 && pressure < 32'sd0))
        else $error("negative pressure item inconsistent");

    a_ok_physical: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && error_code == pscd_pkg::ERR_OK) |-> (density > 32'sd0 && !pressure[31]))
        else $error("good item with nonpositive density or negative pressure");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(density) && $stable(error_code)))
        else $error("waiting result changed");

endmodule

bind primitive_state_from_conserved pscd_chk u_pscd_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .density     (density),
    .pressure    (pressure),
    .sound_speed (sound_speed),
    .enthalpy    (enthalpy),
    .error_code  (error_code)
);

`default_nettype wire

[dv/primitive_state_from_conserved_test.sv]
// self-checking testbench for the conserved-to-primitive cell converter
`default_nettype none

module primitive_state_from_conserved_test;

    typedef struct {
        logic signed [31:0] jinv;
        logic signed [31:0] mass;
        logic signed [31:0] mx;
        logic signed [31:0] my;
        logic signed [31:0] en;
    } cell_t;

    localparam longint WORD_MAX = 64'sd2147483647;
    localparam longint WORD_MIN = -64'sd2147483648;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic signed [31:0] jacobian_inverse = '0;
    logic signed [31:0] mass_term = '0;
    logic signed [31:0] x_momentum_term = '0;
    logic signed [31:0] y_momentum_term = '0;
    logic signed [31:0] energy_term = '0;
    logic               cfg_write = 1'b0;
    logic        [17:0] cfg_data = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic signed [31:0] density;
    logic signed [31:0] x_velocity;
    logic signed [31:0] y_velocity;
    logic signed [31:0] total_energy;
    logic signed [31:0] pressure;
    logic        [30:0] sound_speed;
    logic signed [31:0] enthalpy;
    logic        [1:0]  error_code;

    cell_t                 pending_cells[$];
    pscd_pkg::result_t     expected_cells[$];
    logic [17:0]           gamma_reg = pscd_pkg::GAMMA_RESET;
    bit                    took = 1'b0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    failures = 0;

    primitive_state_from_conserved uut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .jacobian_inverse(jacobian_inverse), .mass_term(mass_term),
        .x_momentum_term(x_momentum_term), .y_momentum_term(y_momentum_term),
        .energy_term(energy_term), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .empty(empty), .pop(pop), .density(density), .x_velocity(x_velocity),
        .y_velocity(y_velocity), .total_energy(total_energy), .pressure(pressure),
        .sound_speed(sound_speed), .enthalpy(enthalpy), .error_code(error_code)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint clip32(input longint v);
        if (v > WORD_MAX)
        begin
            return WORD_MAX;
        end
        if (v < WORD_MIN)
        begin
            return WORD_MIN;
        end
        return v;
    endfunction

    // floor of the product over 2^16
    function automatic longint fix_mul(input longint a, input longint b);
        return clip32((a * b) >>> 16);
    endfunction

    function automatic longint fix_div(input longint a, input longint b);
        if (b == 0)
        begin
            return (a >= 0) ? WORD_MAX : WORD_MIN;
        end
        return clip32((a * 65536) / b);
    endfunction

    function automatic longint fix_sqrt(input longint x);
        longint unsigned n;
        longint unsigned r;
        longint unsigned b;
        if (x <= 0)
        begin
            return 0;
        end
        n = x * 65536;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic pscd_pkg::result_t predict_primitive(input cell_t c,
                                                            input logic [17:0] gcfg);
        longint            g, gm1, rho, ux, vy, e, v2, ke, p, gp;
        pscd_pkg::result_t r;
        g = gcfg;
        if (g < pscd_pkg::GAMMA_MIN)
        begin
            g = pscd_pkg::GAMMA_MIN;
        end
        if (g > pscd_pkg::GAMMA_MAX)
        begin
            g = pscd_pkg::GAMMA_MAX;
        end
        gm1 = g - 65536;
        r = '0;
        r.error_code = pscd_pkg::ERR_OK;
        rho = (c.jinv > 0) ? fix_div(c.mass, c.jinv) : 0;
        if (c.jinv <= 0 || rho <= 0)
        begin
            r.error_code = pscd_pkg::ERR_BAD_CELL;
            return r;
        end
        ux = fix_div(fix_div(c.mx, rho), c.jinv);
        vy = fix_div(fix_div(c.my, rho), c.jinv);
        e = fix_div(c.en, c.jinv);
        v2 = clip32(fix_mul(ux, ux) + fix_mul(vy, vy));
        ke = fix_mul(fix_mul(32768, rho), v2);
        p = fix_mul(clip32(e - ke), gm1);
        gp = fix_mul(g, p);
        r.density = rho[31:0];
        r.x_velocity = ux[31:0];
        r.y_velocity = vy[31:0];
        r.total_energy = e[31:0];
        r.pressure = p[31:0];
        if (p < 0)
        begin
            r.error_code = pscd_pkg::ERR_NEG_PRESSURE;
        end
        else
        begin
            r.sound_speed = 31'(fix_sqrt(fix_div(gp, rho)));
        end
        r.enthalpy = 32'(clip32(fix_div(gp, fix_mul(rho, gm1)) + fix_mul(32768, v2)));
        return r;
    endfunction

    // input side: capture accepted cells and register writes
    always @(posedge clk)
    begin
        cell_t c;
        took = push && !full;
        if (took)
        begin
            c.jinv = jacobian_inverse;
            c.mass = mass_term;
            c.mx = x_momentum_term;
            c.my = y_momentum_term;
            c.en = energy_term;
            expected_cells.push_back(predict_primitive(c, gamma_reg));
        end
        if (cfg_write)
        begin
            gamma_reg = cfg_data;
        end
    end

    // driver
    always @(negedge clk)
    begin
        cell_t c;
        if (rst_n && (!push || took))
        begin
            if (pending_cells.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                c = pending_cells.pop_front();
                jacobian_inverse <= c.jinv;
                mass_term <= c.mass;
                x_momentum_term <= c.mx;
                y_momentum_term <= c.my;
                energy_term <= c.en;
                push <= 1'b1;
            end
            else
            begin
                push <= 1'b0;
            end
        end
        pop <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        pscd_pkg::result_t x;
        if (pop && !empty)
        begin
            if (expected_cells.size() == 0)
            begin
                $display("%0t unexpected result density %h", $time, density);
                failures++;
            end
            else
            begin
                x = expected_cells.pop_front();
                if (density !== x.density || x_velocity !== x.x_velocity ||
                    y_velocity !== x.y_velocity || total_energy !== x.total_energy ||
                    pressure !== x.pressure || sound_speed !== x.sound_speed ||
                    enthalpy !== x.enthalpy || error_code !== x.error_code)
                begin
                    $display("%0t mismatch expected %h %h %h %h %h %h %h %0d", $time,
                             x.density, x.x_velocity, x.y_velocity, x.total_energy,
                             x.pressure, x.sound_speed, x.enthalpy, x.error_code);
                    $display("%0t          actual   %h %h %h %h %h %h %h %0d", $time,
                             density, x_velocity, y_velocity, total_energy,
                             pressure, sound_speed, enthalpy, error_code);
                    failures++;
                end
            end
        end
    end

    task automatic add_cell(input logic [31:0] j, m, mx, my, en);
        cell_t c;
        c.jinv = j;
        c.mass = m;
        c.mx = mx;
        c.my = my;
        c.en = en;
        pending_cells.push_back(c);
    endtask

    task automatic wait_drained();
        wait (pending_cells.size() == 0 && !push && expected_cells.size() == 0);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_gamma(input logic [17:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // mostly physical cells, some fully random words
    task automatic add_random_cells(input int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(7) == 0)
            begin
                add_cell($urandom, $urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                add_cell($urandom_range(32'h0010_0000, 32'h0000_1000),
                         $urandom_range(32'h0040_0000, 32'h0000_0400),
                         $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000,
                         $signed($urandom_range(32'h0020_0000)) - 32'sh0010_0000,
                         $signed($urandom_range(32'h0080_0000)) - 32'sh0010_0000);
            end
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed cells at the reset gamma
        add_cell(32'h0, 32'h0001_0000, 0, 0, 32'h0001_0000);
        add_cell(32'hFFFF_0000, 32'h0001_0000, 0, 0, 32'h0001_0000);
        add_cell(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_cell(32'h0001_0000, 32'h0, 0, 0, 32'h0001_0000);
        add_cell(32'h0001_0000, 32'hFFFF_0000, 0, 0, 32'h0001_0000);
        add_cell(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0010_0000);
        add_cell(32'h0001_0000, 32'h0001_0000, 32'h0004_0000, 32'h0004_0000, 32'h0001_0000);
        add_cell(32'h0001_0000, 32'h0000_0001, 0, 0, 32'h0001_0000);
        add_cell(32'h0001_0000, 32'h0000_0001, 0, 0, 32'hFFFF_0000);
        add_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_cell(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_cell(32'h0000_0001, 32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_cell(32'h0001_0000, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000);
        add_cell(32'h0002_0000, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_8000, 32'h0000_0000);
        add_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cell(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h7FFF_FFFF);
        wait_drained();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 87;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 87;
                end
                default:
                begin
                    send_idle_pct = 36;
                    recv_stall_pct = 36;
                end
            endcase
            case (ph)
                0: write_gamma(18'd65537);
                1: write_gamma(18'd196608);
                2: write_gamma(18'd0);
                3: write_gamma(18'd262143);
                4: write_gamma(pscd_pkg::GAMMA_RESET);
                default: write_gamma(18'($urandom_range(18'h3FFFF)));
            endcase
            add_random_cells(100);
            // hold off until the pipeline has emptied
            if (ph == 3)
            begin
                wait (pending_cells.size() == 0 && !push && expected_cells.size() == 0);
            end
            add_random_cells(100);
            wait_drained();
        end

        if (failures == 0 && expected_cells.size() == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #40000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
